FILE: hdl/wtv_pkg.sv
// Shared types, constants and the sine table for the wavetable voice pool.
// No dependencies; used by wtv_div and the top level.
package wtv_pkg;

   localparam int ACC_W = 32;

   localparam logic [1:0] FLD_ATTACK   = 2'd0;
   localparam logic [1:0] FLD_HOLD_END = 2'd1;
   localparam logic [1:0] FLD_RELEASE  = 2'd2;
   localparam logic [1:0] FLD_WAVEFORM = 2'd3;

   localparam logic [1:0] WAVE_SAW    = 2'd0;
   localparam logic [1:0] WAVE_SINE   = 2'd1;
   localparam logic [1:0] WAVE_SQUARE = 2'd2;

   localparam logic [15:0] ENV_FULL = 16'hFFFF;
   localparam logic [7:0]  SAMPLE_SILENT = 8'd127;

   typedef struct packed {
      logic [15:0] phase;
      logic [15:0] step;
      logic [31:0] ms;
      logic [7:0]  frac;
      logic [7:0]  sub;
      logic [15:0] env;
      logic        inst;
   } voice_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   localparam logic [15:0] QUARTER_SINE [65] = '{
      16'd0, 16'd804, 16'd1608, 16'd2410, 16'd3212, 16'd4011, 16'd4808, 16'd5602,
      16'd6393, 16'd7179, 16'd7962, 16'd8739, 16'd9512, 16'd10278, 16'd11039,
      16'd11793, 16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446, 16'd16151,
      16'd16846, 16'd17530, 16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787,
      16'd21403, 16'd22005, 16'd22594, 16'd23170, 16'd23731, 16'd24279, 16'd24811,
      16'd25329, 16'd25832, 16'd26319, 16'd26790, 16'd27245, 16'd27683, 16'd28105,
      16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956, 16'd30273, 16'd30571,
      16'd30852, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971, 16'd32137,
      16'd32285, 16'd32412, 16'd32520, 16'd32609, 16'd32678, 16'd32728, 16'd32757,
      16'd32767
   };

   // Full-turn sine from the quarter table, Q1.15.
   function automatic logic signed [15:0] sine_value(input logic [7:0] idx);
      logic [6:0]  k;
      logic [15:0] m;
      k = {1'b0, idx[5:0]};
      if (idx[6]) begin
         m = QUARTER_SINE[7'd64 - k];
      end else begin
         m = QUARTER_SINE[k];
      end
      if (idx[7]) begin
         return $signed(16'd0 - m);
      end
      return $signed(m);
   endfunction

endpackage

FILE: hdl/wtv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wtv_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: hdl/wtv_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend, 16-bit divisor.
// Depends on wtv_pkg for the status struct.
module wtv_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [31:0]         dividend,
   input  logic [15:0]         divisor,
   output logic [31:0]         quotient,
   output wtv_pkg::div_stat_type stat
);

   logic [16:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [16:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      shifted = {rem_ff[15:0], quo_ff[31]};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = shifted - {1'b0, dsr_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = (cnt_ff != 6'd0);
   assign stat.done = done_ff;

endmodule

FILE: hdl/wavetable_voice_pool_with_envelope.sv
// Top level of the wavetable voice pool: sequencer, voice RAM and envelope; each voice's sample replaces the last.
// Depends on wtv_pkg, wtv_ram and wtv_div.
//
//  channel | direction | handshake             | contents
//  req     | in        | req_tvalid/req_tready | tuser: op; tdata: phase_step, instrument
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: sample, voices_active, accepted, slot
//  csr     | in        | csr_we                | csr_index, csr_wdata (write only)
//
// A note-on scans the slots up to the first free one. A tick visits every slot; a used
// slot goes through load, multiply, scale and store, and a voice whose envelope is
// recomputed (every ENV_SUBDIV samples) also goes through the envelope state, and the
// 32-step shared divider when its attack or release ramp is in progress.
// Synchronous active-high reset empties the pool and loads the register defaults.
// A finished response sits in the output register; the next request is taken
// meanwhile, and the sequencer holds at the end of an item until that slot drains.
module wavetable_voice_pool_with_envelope #(
   parameter int NUM_VOICES     = 8,
   parameter int ENV_SUBDIV     = 16,
   parameter int SAMPLES_PER_MS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] phase_step, [16] instrument, zero pad
   input  logic        req_tuser,   // [0] op: 0 tick, 1 note on
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] sample, [11:8] voices_active,
                                    // [12] note_accepted, [15:13] slot
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int VW = $clog2(NUM_VOICES + 1);
   localparam int VOICE_W = $bits(wtv_pkg::voice_type);
   localparam logic [7:0] FRAC_LAST = 8'(SAMPLES_PER_MS - 1);
   localparam logic [7:0] SUB_LAST  = 8'(ENV_SUBDIV - 1);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_SCAN   = 10'b00_0000_0010,
      S_VISIT  = 10'b00_0000_0100,
      S_LOAD   = 10'b00_0000_1000,
      S_MUL    = 10'b00_0001_0000,
      S_SCALE  = 10'b00_0010_0000,
      S_ENV    = 10'b00_0100_0000,
      S_DIV    = 10'b00_1000_0000,
      S_STORE  = 10'b01_0000_0000,
      S_FINISH = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers, one set per instrument
   logic [15:0] attack_ff [2];
   logic [15:0] hold_ff   [2];
   logic [15:0] rel_ff    [2];
   logic [1:0]  wave_ff   [2];

   logic [NUM_VOICES-1:0] used_ff, used_in;
   logic [VW-1:0]         count_ff, count_in;
   logic [VW-1:0]         v_ff, v_in;
   logic                  op_ff, op_in;
   logic [15:0]           step_ff, step_in;
   logic                  inst_ff, inst_in;
   wtv_pkg::voice_type    cur_ff, cur_in;
   logic                  upd_ff, upd_in;
   logic                  free_ff, free_in;
   logic signed [32:0]    prod_ff, prod_in;
   logic [7:0]            smp_ff, smp_in;
   logic                  acc_ff, acc_in;
   logic [2:0]            slot_ff, slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_data_ff, rsp_data_in;

   logic                  ram_we;
   wtv_pkg::voice_type    ram_wdata;
   logic [VOICE_W-1:0]    ram_rdata;
   logic [AW-1:0]         vidx;

   logic                  div_start;
   logic [31:0]           div_dividend;
   logic [15:0]           div_divisor;
   logic [31:0]           div_quo;
   wtv_pkg::div_stat_type div_stat;

   logic signed [15:0]    wave;
   logic [31:0]           biased;
   logic [38:0]           scaled;
   logic [15:0]           c_attack, c_hold, c_rel;
   logic [1:0]            c_wave;
   logic [16:0]           rel_end;
   logic [31:0]           rel_left;
   logic [VW+3:0]         count_ext;
   logic [VW+2:0]         v_ext;
   logic                  out_free;

   assign vidx = v_ff[AW-1:0];

   wtv_ram #(
      .WIDTH  (VOICE_W),
      .DEPTH  (NUM_VOICES),
      .ADDR_W (AW)
   ) u_voice_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (vidx),
      .wdata (ram_wdata),
      .raddr (vidx),
      .rdata (ram_rdata)
   );

   wtv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // instrument registers seen by the voice under work
   assign c_attack = attack_ff[cur_ff.inst];
   assign c_hold   = hold_ff[cur_ff.inst];
   assign c_rel    = rel_ff[cur_ff.inst];
   assign c_wave   = wave_ff[cur_ff.inst];
   assign rel_end  = {1'b0, c_hold} + {1'b0, c_rel};
   assign rel_left = {15'd0, rel_end} - cur_ff.ms;

   always_comb begin
      unique case (c_wave)
         wtv_pkg::WAVE_SAW:    wave = $signed({~cur_ff.phase[15], cur_ff.phase[14:0]});
         wtv_pkg::WAVE_SINE:   wave = wtv_pkg::sine_value(cur_ff.phase[15:8]);
         wtv_pkg::WAVE_SQUARE: wave = (cur_ff.phase > 16'h8000) ? 16'sh7FFF : 16'sh8000;
         default:              wave = 16'sd0;
      endcase
   end

   // (p + 2^31) * 127 >> 31; the bias is a flip of bit 31 since p fits 32 bits signed
   assign biased = {~prod_ff[31], prod_ff[30:0]};
   assign scaled = {biased, 7'd0} - {7'd0, biased};

   assign count_ext = {4'd0, count_ff};
   assign v_ext     = {3'd0, v_ff};
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      count_in     = count_ff;
      v_in         = v_ff;
      op_in        = op_ff;
      step_in      = step_ff;
      inst_in      = inst_ff;
      cur_in       = cur_ff;
      upd_in       = upd_ff;
      free_in      = free_ff;
      prod_in      = prod_ff;
      smp_in       = smp_ff;
      acc_in       = acc_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_wdata    = cur_ff;
      div_start    = 1'b0;
      div_dividend = {cur_ff.ms[15:0], 16'd0};
      div_divisor  = c_attack;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tuser;
               step_in = req_tdata[15:0];
               inst_in = req_tdata[16];
               v_in    = '0;
               smp_in  = wtv_pkg::SAMPLE_SILENT;
               acc_in  = 1'b0;
               slot_in = '0;
               state_in = req_tuser ? S_SCAN : S_VISIT;
            end
         end
         S_SCAN: begin
            // walk up to the lowest free slot and claim it
            if (v_ff == VW'(NUM_VOICES)) begin
               state_in = S_FINISH;
            end else if (!used_ff[vidx]) begin
               ram_we          = 1'b1;
               ram_wdata       = '0;
               ram_wdata.step  = step_ff;
               ram_wdata.inst  = inst_ff;
               used_in[vidx]   = 1'b1;
               count_in        = count_ff + VW'(1);
               acc_in          = 1'b1;
               slot_in         = v_ext[2:0];
               state_in        = S_FINISH;
            end else begin
               v_in = v_ff + VW'(1);
            end
         end
         S_VISIT: begin
            if (v_ff == VW'(NUM_VOICES)) begin
               state_in = S_FINISH;
            end else if (used_ff[vidx]) begin
               state_in = S_LOAD;
            end else begin
               v_in = v_ff + VW'(1);
            end
         end
         S_LOAD: begin
            cur_in   = wtv_pkg::voice_type'(ram_rdata);
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = 33'(wave) * $signed({17'd0, cur_ff.env});
            state_in = S_SCALE;
         end
         S_SCALE: begin
            // emit this voice's sample, then advance phase and time counters
            smp_in       = scaled[38:31];
            upd_in       = (cur_ff.sub == 8'd0);
            free_in      = 1'b0;
            cur_in.phase = cur_ff.phase + cur_ff.step;
            cur_in.sub   = (cur_ff.sub == SUB_LAST) ? 8'd0 : cur_ff.sub + 8'd1;
            if (cur_ff.frac == FRAC_LAST) begin
               cur_in.frac = 8'd0;
               cur_in.ms   = cur_ff.ms + 32'd1;
            end else begin
               cur_in.frac = cur_ff.frac + 8'd1;
            end
            state_in = (cur_ff.sub == 8'd0) ? S_ENV : S_STORE;
         end
         S_ENV: begin
            priority if (cur_ff.ms < {16'd0, c_attack}) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else if (cur_ff.ms < {16'd0, c_hold}) begin
               cur_in.env = wtv_pkg::ENV_FULL;
               state_in   = S_STORE;
            end else if (cur_ff.ms < {15'd0, rel_end}) begin
               div_start    = 1'b1;
               div_dividend = {rel_left[15:0], 16'd0};
               div_divisor  = c_rel;
               state_in     = S_DIV;
            end else begin
               cur_in.env = 16'd0;
               free_in    = 1'b1;
               state_in   = S_STORE;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               cur_in.env = (div_quo[31:16] != 16'd0) ? wtv_pkg::ENV_FULL : div_quo[15:0];
               state_in   = S_STORE;
            end
         end
         S_STORE: begin
            ram_we = 1'b1;
            if (free_ff && upd_ff) begin
               used_in[vidx] = 1'b0;
               count_in      = count_ff - VW'(1);
            end
            free_in  = 1'b0;
            v_in     = v_ff + VW'(1);
            state_in = S_VISIT;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {slot_ff, acc_ff, count_ext[3:0], smp_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (op_ff && state_ff != S_IDLE) begin
         smp_in = wtv_pkg::SAMPLE_SILENT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         free_ff      <= 1'b0;
         attack_ff[0] <= 16'd50;
         hold_ff[0]   <= 16'd300;
         rel_ff[0]    <= 16'd1000;
         wave_ff[0]   <= wtv_pkg::WAVE_SAW;
         attack_ff[1] <= 16'd50;
         hold_ff[1]   <= 16'd300;
         rel_ff[1]    <= 16'd2000;
         wave_ff[1]   <= wtv_pkg::WAVE_SINE;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         free_ff      <= free_in;
         if (csr_we) begin
            unique case (csr_index[1:0])
               wtv_pkg::FLD_ATTACK:   attack_ff[csr_index[2]] <= csr_wdata;
               wtv_pkg::FLD_HOLD_END: hold_ff[csr_index[2]]   <= csr_wdata;
               wtv_pkg::FLD_RELEASE:  rel_ff[csr_index[2]]    <= csr_wdata;
               wtv_pkg::FLD_WAVEFORM: wave_ff[csr_index[2]]   <= csr_wdata[1:0];
               default: ;
            endcase
         end
      end
      v_ff        <= v_in;
      op_ff       <= op_in;
      step_ff     <= step_in;
      inst_ff     <= inst_in;
      cur_ff      <= cur_in;
      upd_ff      <= upd_in;
      prod_ff     <= prod_in;
      smp_ff      <= smp_in;
      acc_ff      <= acc_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: hdl/wtv_checker.sv
// Port-level checks for the wavetable voice pool, bound to the top level.
// Depends on wavetable_voice_pool_with_envelope.
module wtv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:0] != 8'hFF)
      else $error("sample out of range");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[12] |-> rsp_tdata[15:13] == 3'd0)
      else $error("slot set without accepted note");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind wavetable_voice_pool_with_envelope wtv_checker u_wtv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
